// ===== rtl/core/olt_pkg.sv =====
package olt_pkg;

   typedef enum logic [2:0] {
      KIND_INSERT    = 3'd0,
      KIND_APPEND    = 3'd1,
      KIND_READ      = 3'd2,
      KIND_OVERWRITE = 3'd3,
      KIND_REMOVE    = 3'd4,
      KIND_FIND      = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  item_index;
      logic [31:0] item_value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_value;
      logic [5:0]  found_index;
      logic [6:0]  entry_count;
      logic        is_empty;
   } rsp_payload_type;

endpackage

// ===== rtl/core/olt_stream_if.sv =====
interface olt_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/olt_ram.sv =====
module olt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/ordered_list_table_core.sv =====
// Range and full errors, spare kinds and find on an empty list go straight to the result;
// append or insert at the end writes the RAM directly; read, overwrite, insert, remove and find
// first scan the RAM entry by entry (find stops at the first match).
// Throughput: one word in flight; ready returns together with result valid, and a finished word
// waits while an earlier result still waits on the sink.
// Reset (synchronous): entry count cleared, no result pending; RAM contents not cleared.
module ordered_list_table_core #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   olt_stream_if.sink   req_chan,
   olt_stream_if.source rsp_chan
);
   import olt_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > 6) ? CW : 6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_TAIL,
      S_WRITE,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [2:0]       kind_ff, kind_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [AW-1:0]    end_ff, end_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [AW-1:0]    rd_addr_ff, rd_addr_in;
   logic [1:0]       status_ff, status_in;
   logic [VALUE_WIDTH-1:0] rval_ff, rval_in;
   logic [AW-1:0]    fidx_ff, fidx_in;
   logic             found_ff, found_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             rsp_vld_ff, rsp_vld_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_wa;
   logic [VALUE_WIDTH-1:0] ram_wd;
   logic                   ram_re;
   logic [AW-1:0]          ram_ra;
   logic [VALUE_WIDTH-1:0] ram_rd;

   logic [CMP_W-1:0] idx_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] tgt_ext;
   logic [AW-1:0]    cnt_m1;
   logic             write_back;

   assign idx_ext    = CMP_W'(req_chan.payload.item_index);
   assign cnt_ext    = CMP_W'(count_ff);
   assign cnt_m1     = AW'(count_ff - 1'b1);
   assign write_back = (kind_ff == KIND_INSERT) || (kind_ff == KIND_APPEND)
                       || (kind_ff == KIND_OVERWRITE);
   assign tgt_ext    = (req_chan.payload.kind == KIND_APPEND) ? cnt_ext : idx_ext;

   olt_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      idx_in      = idx_ff;
      val_in      = val_ff;
      ptr_in      = ptr_ff;
      end_in      = end_ff;
      rd_vld_in   = 1'b0;
      rd_addr_in  = ptr_ff;
      status_in   = status_ff;
      rval_in     = rval_ff;
      fidx_in     = fidx_ff;
      found_in    = found_ff;
      count_in    = count_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;
      rsp_data_in = rsp_data_ff;
      ram_we      = 1'b0;
      ram_wa      = idx_ff;
      ram_wd      = val_ff;
      ram_re      = 1'b0;
      ram_ra      = ptr_ff;

      // entry returned from the read issued last cycle
      if (rd_vld_ff) begin
         case (kind_ff) inside
            KIND_INSERT, KIND_APPEND: begin
               ram_we = 1'b1;
               ram_wa = rd_addr_ff + 1'b1;
               ram_wd = ram_rd;
            end
            KIND_REMOVE: begin
               if (rd_addr_ff == idx_ff) begin
                  rval_in = ram_rd;
               end else begin
                  ram_we = 1'b1;
                  ram_wa = rd_addr_ff - 1'b1;
                  ram_wd = ram_rd;
               end
            end
            KIND_READ, KIND_OVERWRITE: begin
               rval_in = ram_rd;
            end
            KIND_FIND: begin
               if (!found_ff && ram_rd == val_ff) begin
                  found_in  = 1'b1;
                  status_in = ST_OK;
                  fidx_in   = rd_addr_ff;
               end
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               kind_in   = req_chan.payload.kind;
               idx_in    = AW'(req_chan.payload.item_index);
               val_in    = VALUE_WIDTH'(req_chan.payload.item_value);
               status_in = ST_OK;
               rval_in   = '0;
               fidx_in   = '0;
               found_in  = 1'b0;
               state_in  = S_DONE;
               case (req_chan.payload.kind) inside
                  KIND_INSERT, KIND_APPEND: begin
                     if (tgt_ext > cnt_ext) begin
                        status_in = ST_RANGE;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        idx_in   = AW'(tgt_ext);
                        ptr_in   = cnt_m1;
                        end_in   = AW'(tgt_ext);
                        state_in = (tgt_ext == cnt_ext) ? S_WRITE : S_SCAN;
                     end
                  end
                  KIND_READ, KIND_OVERWRITE, KIND_REMOVE: begin
                     if (idx_ext >= cnt_ext) begin
                        status_in = ST_RANGE;
                     end else begin
                        ptr_in   = AW'(req_chan.payload.item_index);
                        end_in   = (req_chan.payload.kind == KIND_REMOVE) ? cnt_m1
                                   : AW'(req_chan.payload.item_index);
                        state_in = S_SCAN;
                     end
                  end
                  KIND_FIND: begin
                     status_in = ST_NOT_FOUND;
                     if (count_ff != '0) begin
                        ptr_in   = '0;
                        end_in   = cnt_m1;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            ram_re     = 1'b1;
            ram_ra     = ptr_ff;
            rd_vld_in  = 1'b1;
            rd_addr_in = ptr_ff;
            if (ptr_ff == end_ff || found_in) begin
               state_in = S_TAIL;
            end else if (kind_ff == KIND_INSERT || kind_ff == KIND_APPEND) begin
               ptr_in = ptr_ff - 1'b1;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_TAIL: begin
            state_in = write_back ? S_WRITE : S_DONE;
         end
         S_WRITE: begin
            ram_we   = 1'b1;
            ram_wa   = idx_ff;
            ram_wd   = val_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               if (status_ff == ST_OK
                   && (kind_ff == KIND_INSERT || kind_ff == KIND_APPEND)) begin
                  count_in = count_ff + 1'b1;
               end else if (status_ff == ST_OK && kind_ff == KIND_REMOVE) begin
                  count_in = count_ff - 1'b1;
               end
               rsp_data_in.status       = status_ff;
               rsp_data_in.result_value = 32'(rval_ff);
               rsp_data_in.found_index  = 6'(fidx_ff);
               rsp_data_in.entry_count  = 7'(count_in);
               rsp_data_in.is_empty     = (count_in == '0);
               rsp_vld_in               = 1'b1;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      kind_ff     <= kind_in;
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      ptr_ff      <= ptr_in;
      end_ff      <= end_in;
      rd_addr_ff  <= rd_addr_in;
      status_ff   <= status_in;
      rval_ff     <= rval_in;
      fidx_ff     <= fidx_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
